// ===== hdl/assert_macros.svh =====
// assertion macros used by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clock edge out of reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gcld_pkg.sv =====
// types and constants of the gaussian copula log density core
`timescale 1ns / 1ps
`default_nettype none

package gcld_pkg;

  localparam int unsigned MAX_DIMENSION = 64;
  localparam int unsigned DIM_W         = $clog2(MAX_DIMENSION);
  localparam int unsigned CNT_W         = DIM_W + 1;
  localparam int unsigned FM_AW         = 2 * DIM_W;
  localparam int unsigned FM_DEPTH      = 2 ** FM_AW;
  localparam int unsigned SQ_W          = 96;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_SCORE = 1'b1
  } func_e;

  typedef enum logic {
    CFG_DIMENSION = 1'b0,
    CFG_LOG_DET   = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DOT,
    ST_ABS,
    ST_SQ_HH,
    ST_SQ_HL,
    ST_SQ_LL,
    ST_MARG,
    ST_ACCUM,
    ST_RES1,
    ST_RES2,
    ST_RES3,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic              func;
    logic [5:0]        row_index;
    logic [5:0]        col_index;
    logic signed [31:0] value;
    logic              batch_end;
  } in_req_t;

  typedef struct packed {
    logic signed [63:0] row_log_density;
    logic signed [63:0] log_likelihood;
    logic [31:0]        row_number;
    logic               failed;
    logic [31:0]        failure_row;
    logic               batch_done;
  } out_res_t;

endpackage

`default_nettype wire

// ===== hdl/gaussian_copula_dense_log_density_core.sv =====
// Gaussian copula log density core, dense inverse-Cholesky form, Q8.24 in, Q32.32 out.
//
// Input channel (in_valid_i / in_ready_o / in_req_i): a request with func = write stores
// one factor entry. A request with func = score brings the next score of the current row.
// Output channel (out_valid_o / out_ready_i / out_res_o): one result per finished row.
// Configuration: cfg_we_i writes cfg_data_i into the register picked by cfg_idx_i (0 =
// dimension in use, 1 = log determinant); the user must do so only while the core is idle,
// which the core itself does not enforce. Score element i runs i+1 multiply-accumulates
// through the one shared 33x33 multiplier, pipelined one per cycle behind the registered
// factor and score memory reads, then three multiplies for the square of the dot product
// and one for the score squared, the core not ready meanwhile. The element that closes a
// row then passes through RES1, RES2, RES3 and FIN for the row result and likelihood update.
// in_ready_o is high only in idle.
// The result sits in an output register; the core takes new requests while it waits.
// A row end that finds the register still full holds until the receiver takes it.
// Reset clears sums, counters, flags and the registers (dimension 1, log determinant 0);
// factor and score memories are not cleared and must be written before they are read.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gaussian_copula_dense_log_density_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire gcld_pkg::in_req_t in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output gcld_pkg::out_res_t     out_res_o,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [63:0]       cfg_data_i
);
  import gcld_pkg::*;

  localparam logic [63:0] SAT_MAX = {1'b0, {63{1'b1}}};

  // exact 65-bit sum folded to 64 bits with saturation, overflow flag on top
  function automatic logic [64:0] sat65(input logic [64:0] s);
    logic [64:0] r;
    if (s[64] != s[63]) begin
      r = {1'b1, s[64], {63{~s[64]}}};
    end else begin
      r = {1'b0, s[63:0]};
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic [6:0]        dim_q;
  logic [63:0]       ld_q;
  logic [DIM_W-1:0]  elem_cnt_q;
  logic [DIM_W-1:0]  j_q;
  logic              issuing_q;
  logic              rd_vld_q;
  logic              prod_vld_q;
  logic [63:0]       joint_q;
  logic [63:0]       marg_q;
  logic [63:0]       lsum_q;
  logic [31:0]       row_cnt_q;
  logic              failed_q;
  logic [31:0]       failed_row_q;
  logic              row_ov_q;
  logic              out_valid_q;
  out_res_t          out_res_q;

  logic [31:0]        fm_mem [FM_DEPTH];
  logic [31:0]        rs_mem [MAX_DIMENSION];
  logic [31:0]        fm_rd_q;
  logic [31:0]        rs_rd_q;
  logic signed [65:0] mult_q;
  logic [63:0]        w_q;
  logic [63:0]        abs_q;
  logic [SQ_W-1:0]    sq_acc_q;
  logic [31:0]        v_q;
  logic               be_q;
  logic [64:0]        half_a_q;
  logic [64:0]        half_b_q;
  logic               par_q;
  logic [63:0]        res_q;

  logic               in_fire;
  logic               score_fire;
  logic               write_fire;
  logic               out_free;
  logic               fin_go;
  logic               dot_done;
  logic [CNT_W-1:0]   dim_eff;
  logic               row_last;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic [63:0]        dot_term;
  logic               sq_ov;
  logic [63:0]        sq_sat;
  logic [63:0]        joint_sum;
  logic [63:0]        marg_sum;
  logic [63:0]        marg_term;
  logic [63:0]        diff;
  logic [64:0]        res_sat;
  logic [64:0]        res2_sat;
  logic [64:0]        lsum_sum;
  logic               lsum_ov;
  logic [63:0]        lsum_nx;
  logic               failed_nx;
  logic [31:0]        frow_nx;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign score_fire  = in_fire && (in_req_i.func == FUNC_SCORE);
  assign write_fire  = in_fire && (in_req_i.func == FUNC_WRITE) &&
                       (32'(in_req_i.row_index) < MAX_DIMENSION) &&
                       (32'(in_req_i.col_index) < MAX_DIMENSION);
  assign out_free    = !out_valid_q || out_ready_i;
  assign fin_go      = (state_q == ST_FIN) && out_free;
  assign dot_done    = !issuing_q && !rd_vld_q && !prod_vld_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // dimension 0 acts as 1, anything past the matrix order as the order
  always_comb begin
    if (dim_q == '0) begin
      dim_eff = CNT_W'(1);
    end else if (32'(dim_q) > MAX_DIMENSION) begin
      dim_eff = CNT_W'(MAX_DIMENSION);
    end else begin
      dim_eff = CNT_W'(dim_q);
    end
  end

  assign row_last = ({1'b0, elem_cnt_q} + CNT_W'(1)) >= dim_eff;

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      ST_DOT: begin
        mul_a = {fm_rd_q[31], fm_rd_q};
        mul_b = {rs_rd_q[31], rs_rd_q};
      end
      ST_SQ_HH: begin
        mul_a = {1'b0, abs_q[63:32]};
        mul_b = {1'b0, abs_q[63:32]};
      end
      ST_SQ_HL: begin
        mul_a = {1'b0, abs_q[63:32]};
        mul_b = {1'b0, abs_q[31:0]};
      end
      ST_SQ_LL: begin
        mul_a = {1'b0, abs_q[31:0]};
        mul_b = {1'b0, abs_q[31:0]};
      end
      ST_MARG: begin
        mul_a = {v_q[31], v_q};
        mul_b = {v_q[31], v_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Q16.48 product floored to Q32.32
  assign dot_term  = {{14{mult_q[65]}}, mult_q[65:16]};
  assign marg_term = {16'd0, mult_q[63:16]};

  assign sq_ov     = |sq_acc_q[SQ_W-1:63];
  assign sq_sat    = sq_ov ? SAT_MAX : sq_acc_q[63:0];
  assign joint_sum = joint_q + sq_sat;
  assign marg_sum  = marg_q + marg_term;
  assign diff      = marg_q - joint_q;
  assign res_sat   = sat65(half_a_q + half_b_q);
  assign res2_sat  = sat65({res_q[63], res_q} + {64'd0, par_q});
  assign lsum_sum  = {lsum_q[63], lsum_q} + {res_q[63], res_q};
  assign lsum_ov   = lsum_sum[64] != lsum_sum[63];

  // likelihood update at row end; nothing accumulates once the batch failed
  always_comb begin
    lsum_nx   = lsum_q;
    failed_nx = failed_q;
    frow_nx   = failed_row_q;
    if (!failed_q) begin
      if (row_ov_q || lsum_ov) begin
        failed_nx = 1'b1;
        frow_nx   = row_cnt_q;
      end else begin
        lsum_nx = lsum_sum[63:0];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (score_fire) state_d = ST_DOT;
      ST_DOT:   if (dot_done) state_d = ST_ABS;
      ST_ABS:   state_d = ST_SQ_HH;
      ST_SQ_HH: state_d = ST_SQ_HL;
      ST_SQ_HL: state_d = ST_SQ_LL;
      ST_SQ_LL: state_d = ST_MARG;
      ST_MARG:  state_d = ST_ACCUM;
      ST_ACCUM: state_d = row_last ? ST_RES1 : ST_IDLE;
      ST_RES1:  state_d = ST_RES2;
      ST_RES2:  state_d = ST_RES3;
      ST_RES3:  state_d = ST_FIN;
      ST_FIN:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      dim_q        <= 7'd1;
      ld_q         <= '0;
      elem_cnt_q   <= '0;
      j_q          <= '0;
      issuing_q    <= 1'b0;
      rd_vld_q     <= 1'b0;
      prod_vld_q   <= 1'b0;
      joint_q      <= '0;
      marg_q       <= '0;
      lsum_q       <= '0;
      row_cnt_q    <= '0;
      failed_q     <= 1'b0;
      failed_row_q <= '0;
      row_ov_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= issuing_q;
      prod_vld_q <= rd_vld_q;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DIMENSION: dim_q <= cfg_data_i[6:0];
          CFG_LOG_DET:   ld_q  <= cfg_data_i;
          default:       ld_q  <= ld_q;
        endcase
      end

      if (score_fire) begin
        j_q       <= '0;
        issuing_q <= 1'b1;
      end else if (issuing_q) begin
        if (j_q == elem_cnt_q) begin
          issuing_q <= 1'b0;
        end else begin
          j_q <= j_q + DIM_W'(1);
        end
      end

      if (state_q == ST_ACCUM) begin
        joint_q  <= sq_ov || joint_sum[63] ? SAT_MAX : joint_sum;
        marg_q   <= marg_sum[63] ? SAT_MAX : marg_sum;
        row_ov_q <= row_ov_q || sq_ov || joint_sum[63] || marg_sum[63];
        elem_cnt_q <= row_last ? '0 : elem_cnt_q + DIM_W'(1);
      end

      if ((state_q == ST_RES2 && res_sat[64]) || (state_q == ST_RES3 && res2_sat[64])) begin
        row_ov_q <= 1'b1;
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (fin_go) begin
        out_valid_q <= 1'b1;
        joint_q     <= '0;
        marg_q      <= '0;
        row_ov_q    <= 1'b0;
        if (be_q) begin
          lsum_q       <= '0;
          row_cnt_q    <= '0;
          failed_q     <= 1'b0;
          failed_row_q <= '0;
        end else begin
          lsum_q       <= lsum_nx;
          row_cnt_q    <= row_cnt_q + 32'd1;
          failed_q     <= failed_nx;
          failed_row_q <= frow_nx;
        end
      end
    end
  end

  // factor memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (write_fire) begin
      fm_mem[{DIM_W'(in_req_i.row_index), DIM_W'(in_req_i.col_index)}] <= in_req_i.value;
    end
    fm_rd_q <= fm_mem[{elem_cnt_q, j_q}];
  end

  // row score memory
  always_ff @(posedge clk_i) begin
    if (score_fire) begin
      rs_mem[elem_cnt_q] <= in_req_i.value;
    end
    rs_rd_q <= rs_mem[j_q];
  end

  always_ff @(posedge clk_i) begin
    mult_q <= mul_a * mul_b;

    if (score_fire) begin
      v_q      <= in_req_i.value;
      be_q     <= in_req_i.batch_end;
      w_q      <= '0;
      sq_acc_q <= '0;
    end

    if (prod_vld_q) begin
      w_q <= w_q + dot_term;
    end

    case (state_q)
      ST_ABS:   abs_q    <= w_q[63] ? (64'd0 - w_q) : w_q;
      // square as hi*hi*2^32 + 2*hi*lo + floor(lo*lo / 2^32)
      ST_SQ_HL: sq_acc_q <= sq_acc_q + {mult_q[63:0], 32'd0};
      ST_SQ_LL: sq_acc_q <= sq_acc_q + {31'd0, mult_q[63:0], 1'b0};
      ST_MARG:  sq_acc_q <= sq_acc_q + {64'd0, mult_q[63:32]};
      ST_RES1: begin
        // -ceil(ld / 2) and floor((marginal - joint) / 2), parities kept for the carry
        half_a_q <= 65'd0 - {ld_q[63], ld_q[63], ld_q[63:1]} - {64'd0, ld_q[0]};
        half_b_q <= {diff[63], diff[63], diff[63:1]};
        par_q    <= ld_q[0] & diff[0];
      end
      ST_RES2:  res_q <= res_sat[63:0];
      ST_RES3:  res_q <= res2_sat[63:0];
      default:  abs_q <= abs_q;
    endcase

    if (fin_go) begin
      out_res_q.row_log_density <= res_q;
      out_res_q.log_likelihood  <= lsum_nx;
      out_res_q.row_number      <= row_cnt_q;
      out_res_q.failed          <= failed_nx;
      out_res_q.failure_row     <= frow_nx;
      out_res_q.batch_done      <= be_q;
    end
  end

  `ASSERT_NXT(a_score_starts_dot, score_fire, (state_q == ST_DOT) && issuing_q, "score request did not start the dot product")
  `ASSERT_IMP(a_pipe_only_in_dot, rd_vld_q || prod_vld_q || issuing_q, state_q == ST_DOT, "dot product pipeline active outside its phase")
  `ASSERT_IMP(a_fail_row_clear, !failed_q, failed_row_q == '0, "failure row set without failure")
  `ASSERT_NXT(a_fin_emits, fin_go, out_valid_q && (out_res_q.row_log_density == $past(res_q)), "row end did not load the result")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// testbench of the gaussian copula log density core: directed and random requests, checked per row
`timescale 1ns / 1ps

module tb_top;
  import gcld_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned SCORE_TARGET  = 800;
  localparam int unsigned SETTLE_CYCLES = 200;

  class log_density_scoreboard;
    localparam logic signed [65:0] SAT_HI = 66'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [65:0] SAT_LO = -66'sh0_8000_0000_0000_0000;

    logic signed [31:0] factor_mem [MAX_DIMENSION * MAX_DIMENSION];
    logic signed [31:0] score_mem [MAX_DIMENSION];
    int unsigned        elem_cnt = 0;
    logic signed [63:0] joint_acc = '0;
    logic signed [63:0] marginal_acc = '0;
    logic signed [63:0] likelihood_acc = '0;
    logic [31:0]        row_cnt = '0;
    logic [31:0]        first_fail_row = '0;
    bit                 fail_seen = 1'b0;
    bit                 row_ovf = 1'b0;
    logic [6:0]         dim_reg = 7'd1;
    logic signed [63:0] log_det_reg = '0;
    out_res_t           expected_rows [$];
    int unsigned        errors = 0;

    function new();
      foreach (factor_mem[k]) factor_mem[k] = '0;
      foreach (score_mem[k]) score_mem[k] = '0;
    endfunction

    function logic signed [63:0] clamp(input logic signed [65:0] x, inout bit ovf);
      if (x > SAT_HI) begin
        ovf = 1'b1;
        return SAT_HI[63:0];
      end
      if (x < SAT_LO) begin
        ovf = 1'b1;
        return SAT_LO[63:0];
      end
      return x[63:0];
    endfunction

    function logic signed [63:0] add_clamped(input logic signed [63:0] a, input logic signed [63:0] b,
                                             inout bit ovf);
      logic signed [65:0] wa, wb;
      wa = a;
      wb = b;
      return clamp(wa + wb, ovf);
    endfunction

    // Q8.24 x Q8.24 down to Q32.32, floor
    function logic signed [63:0] q_product(input logic signed [31:0] a, input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return p >>> 16;
    endfunction

    function logic signed [63:0] q_square(input logic signed [63:0] w, inout bit ovf);
      logic [127:0] mag;
      mag = (w < 0) ? -w : w;
      mag = (mag * mag) >> 32;
      if (mag > 128'h7FFF_FFFF_FFFF_FFFF) begin
        ovf = 1'b1;
        return 64'sh7FFF_FFFF_FFFF_FFFF;
      end
      return mag[63:0];
    endfunction

    function void set_config(input cfg_idx_e idx, input logic [63:0] data);
      if (idx == CFG_DIMENSION) dim_reg = data[6:0];
      else log_det_reg = data;
    endfunction

    function int unsigned pending();
      return expected_rows.size();
    endfunction

    function void note_request(input in_req_t req);
      int unsigned        d, i, j;
      logic signed [63:0] dot, sq, res, sum;
      logic signed [65:0] ld, mg, jt;
      bit                 ovf, sum_ovf;
      out_res_t           exp_row;
      if (req.func == FUNC_WRITE) begin
        factor_mem[req.row_index * MAX_DIMENSION + req.col_index] = req.value;
        return;
      end
      d = (dim_reg == 0) ? 1 : (dim_reg > MAX_DIMENSION) ? MAX_DIMENSION : dim_reg;
      i = (elem_cnt >= MAX_DIMENSION) ? MAX_DIMENSION - 1 : elem_cnt;
      score_mem[i] = req.value;
      dot = '0;
      for (j = 0; j <= i; j++) dot += q_product(factor_mem[i * MAX_DIMENSION + j], score_mem[j]);
      ovf = 1'b0;
      sq = q_square(dot, ovf);
      joint_acc = add_clamped(joint_acc, sq, ovf);
      marginal_acc = add_clamped(marginal_acc, q_product(req.value, req.value), ovf);
      if (ovf) row_ovf = 1'b1;
      // a lowered dimension closes the row on the current element
      if (i + 1 < d) begin
        elem_cnt = i + 1;
        return;
      end
      ovf = row_ovf;
      ld = log_det_reg;
      mg = marginal_acc;
      jt = joint_acc;
      res = clamp((mg - jt - ld) >>> 1, ovf);
      if (!fail_seen) begin
        sum_ovf = 1'b0;
        sum = add_clamped(likelihood_acc, res, sum_ovf);
        if (ovf || sum_ovf) begin
          fail_seen = 1'b1;
          first_fail_row = row_cnt;
        end else begin
          likelihood_acc = sum;
        end
      end
      exp_row.row_log_density = res;
      exp_row.log_likelihood  = likelihood_acc;
      exp_row.row_number      = row_cnt;
      exp_row.failed          = fail_seen;
      exp_row.failure_row     = fail_seen ? first_fail_row : '0;
      exp_row.batch_done      = req.batch_end;
      expected_rows.push_back(exp_row);
      elem_cnt = 0;
      joint_acc = '0;
      marginal_acc = '0;
      row_ovf = 1'b0;
      row_cnt = row_cnt + 1;
      if (req.batch_end) begin
        likelihood_acc = '0;
        row_cnt = '0;
        fail_seen = 1'b0;
        first_fail_row = '0;
      end
    endfunction

    function void compare_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%h, got 0x%h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(input out_res_t got);
      out_res_t want;
      if (expected_rows.size() == 0) begin
        $error("row result with none pending, row_number 0x%h", got.row_number);
        errors++;
        return;
      end
      want = expected_rows.pop_front();
      compare_field("row_log_density", want.row_log_density, got.row_log_density);
      compare_field("log_likelihood", want.log_likelihood, got.log_likelihood);
      compare_field("row_number", want.row_number, got.row_number);
      compare_field("failed", want.failed, got.failed);
      compare_field("failure_row", want.failure_row, got.failure_row);
      compare_field("batch_done", want.batch_done, got.batch_done);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_req_t     in_req;
  logic        out_valid;
  logic        out_ready;
  out_res_t    out_res;
  logic        cfg_we;
  logic        cfg_idx;
  logic [63:0] cfg_data;

  log_density_scoreboard sb;
  bit          entry_written [MAX_DIMENSION * MAX_DIMENSION];
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned score_items = 0;

  gaussian_copula_dense_log_density_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_res_o   (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_req_t make_write(input int unsigned r, input int unsigned c,
                                         input logic signed [31:0] v, input bit be);
    in_req_t req;
    req.func      = FUNC_WRITE;
    req.row_index = r[5:0];
    req.col_index = c[5:0];
    req.value     = v;
    req.batch_end = be;
    return req;
  endfunction

  function automatic logic signed [31:0] pick_value(input int unsigned wild_pct);
    if ($urandom_range(0, 99) < wild_pct) begin
      case ($urandom_range(0, 4))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return '0;
        default: return $urandom;
      endcase
    end
    // roughly within +-2.0
    return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
  endfunction

  function automatic logic [63:0] pick_log_det();
    logic signed [63:0] t;
    case ($urandom_range(0, 7))
      0: return 64'h7FFF_FFFF_FFFF_FFFF;
      1: return 64'h8000_0000_0000_0000;
      2: return '0;
      3: return {$urandom, $urandom};
      default: begin
        t = $signed($urandom);
        return t <<< 5;
      end
    endcase
  endfunction

  function automatic int unsigned pick_rate();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 8;
      default: return 25;
    endcase
  endfunction

  // valid stays up after acceptance until the next request or an explicit drop in the same step
  task automatic send_req(input in_req_t req);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_req   <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    if (req.func == FUNC_WRITE) entry_written[req.row_index * MAX_DIMENSION + req.col_index] = 1'b1;
  endtask

  task automatic send_score(input logic signed [31:0] v, input bit be);
    in_req_t req;
    req.func      = FUNC_SCORE;
    req.row_index = $urandom;
    req.col_index = $urandom;
    req.value     = v;
    req.batch_end = be;
    send_req(req);
    score_items++;
  endtask

  task automatic ensure_rows(input int unsigned need, input int unsigned wild_pct);
    for (int unsigned r = 0; r < need; r++)
      for (int unsigned c = 0; c <= r; c++)
        if (!entry_written[r * MAX_DIMENSION + c])
          send_req(make_write(r, c, pick_value(wild_pct), $urandom_range(0, 7) == 0));
  endtask

  task automatic push_config(input cfg_idx_e idx, input logic [63:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(idx, data);
    @(posedge clk);
  endtask

  // an element that closes no row may still be computing after the last result
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_res);
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("gaussian_copula_dense_log_density_core test failed");
    $finish;
  end

  initial begin
    int unsigned dim_cfg, eff_d, wild, need, rows, n;
    logic [63:0] dim_data;
    sb = new();
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_req   <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CFG_DIMENSION;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, dimension 1 from reset
    send_req(make_write(0, 0, 32'sh7FFF_FFFF, 1'b0));
    send_req(make_write(1, 0, 32'sh8000_0000, 1'b0));
    send_req(make_write(1, 1, 32'sh7FFF_FFFF, 1'b0));
    // above the diagonal, batch end on a write is ignored
    send_req(make_write(0, 63, -32'sd1, 1'b1));
    send_req(make_write(63, 63, '0, 1'b0));
    ensure_rows(4, 50);
    send_score(32'sh7FFF_FFFF, 1'b0);
    send_score(32'sh8000_0000, 1'b1);
    send_score('0, 1'b0);
    wait_idle();

    // overflowing row marks the batch failed, later rows are not accumulated
    push_config(CFG_LOG_DET, 64'h7FFF_FFFF_FFFF_FFFF);
    push_config(CFG_DIMENSION, 64'd3);
    send_score(32'sh7FFF_FFFF, 1'b0);
    send_score(32'sh7FFF_FFFF, 1'b1);
    send_score(32'sh7FFF_FFFF, 1'b0);
    send_score(pick_value(0), 1'b0);
    send_score(pick_value(0), 1'b0);
    send_score(pick_value(0), 1'b1);
    wait_idle();

    // dimension lowered mid-row, then the likelihood sum saturates
    push_config(CFG_LOG_DET, 64'h8000_0000_0000_0000);
    push_config(CFG_DIMENSION, 64'd4);
    send_score(pick_value(0), 1'b0);
    send_score(pick_value(0), 1'b0);
    wait_idle();
    push_config(CFG_DIMENSION, 64'd1);
    send_score(pick_value(0), 1'b0);
    send_score(pick_value(0), 1'b0);
    send_score(pick_value(0), 1'b1);
    wait_idle();

    // dimension zero acts as one
    push_config(CFG_DIMENSION, 64'd0);
    send_score(pick_value(0), 1'b0);
    send_score(pick_value(0), 1'b1);

    score_items = 0;
    while (score_items < SCORE_TARGET) begin
      wait_idle();
      if (score_items + 100 > SCORE_TARGET) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = pick_rate();
        stall_pct = pick_rate();
      end
      case ($urandom_range(0, 19))
        0:       dim_cfg = 0;
        1:       dim_cfg = MAX_DIMENSION;
        2:       dim_cfg = $urandom_range(MAX_DIMENSION + 1, 127);
        3, 4:    dim_cfg = $urandom_range(7, 20);
        default: dim_cfg = $urandom_range(1, 6);
      endcase
      // upper data bits are don't care for the dimension
      dim_data = {$urandom, $urandom};
      dim_data[6:0] = dim_cfg[6:0];
      push_config(CFG_DIMENSION, dim_data);
      if ($urandom_range(0, 1) == 0) push_config(CFG_LOG_DET, pick_log_det());
      eff_d = (dim_cfg == 0) ? 1 : (dim_cfg > MAX_DIMENSION) ? MAX_DIMENSION : dim_cfg;
      wild  = (eff_d > 8) ? 1 : 15;
      need  = (sb.elem_cnt + 1 > eff_d) ? sb.elem_cnt + 1 : eff_d;
      ensure_rows(need, wild);
      rows = (eff_d > 16) ? 1 : $urandom_range(2, 10);
      repeat (rows) begin
        if ($urandom_range(0, 7) == 0)
          send_req(make_write($urandom_range(0, 63), $urandom_range(0, 63), pick_value(wild),
                              $urandom_range(0, 3) == 0));
        n = (sb.elem_cnt + 1 >= eff_d) ? 1 : eff_d - sb.elem_cnt;
        for (int unsigned k = 0; k < n; k++) begin
          if (k == n - 1) send_score(pick_value(wild), $urandom_range(0, 3) == 0);
          else send_score(pick_value(wild), $urandom_range(0, 15) == 0);
        end
      end
      // leave a row half done so the next setting lands mid-row
      if (eff_d > 1 && $urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, eff_d - 1)) send_score(pick_value(wild), $urandom_range(0, 15) == 0);
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("gaussian_copula_dense_log_density_core test passed");
    end else begin
      $display("gaussian_copula_dense_log_density_core test failed");
    end
    $finish;
  end

endmodule

// ===== gaussian_copula_dense_log_density_core.f =====
+incdir+hdl
hdl/gcld_pkg.sv
hdl/gaussian_copula_dense_log_density_core.sv
test/tb_top.sv
